>>> rtl/aliquot_sum_classifier_defines.svh
// assertion macros shared by the aliquot sum classifier rtl
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ALIQUOT_SUM_CLASSIFIER_DEFINES_SVH
`define ALIQUOT_SUM_CLASSIFIER_DEFINES_SVH

`ifndef ASSERT_OFF

// check sampled on the clock, muted while reset is held
`define ASC_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check sampled on the clock with no reset qualifier
`define ASC_ASSERT_NR(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASC_ASSERT(name, clk, rst_n, prop, msg)
`define ASC_ASSERT_NR(name, clk, prop, msg)

`endif

`endif

>>> rtl/asc_pkg.sv
// constants, codes and controller/datapath link types for the aliquot sum classifier
// no dependencies
`default_nettype none

package asc_pkg;

    localparam int VALUE_WIDTH   = 16;
    localparam int SUM_WIDTH     = 18;
    localparam int CLASS_WIDTH   = 2;
    localparam int ACC_WIDTH     = (VALUE_WIDTH + 4 > SUM_WIDTH) ? VALUE_WIDTH + 4 : SUM_WIDTH + 1;
    localparam int STEP_WIDTH    = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int S_TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((SUM_WIDTH + CLASS_WIDTH + 7) / 8) * 8;

    localparam logic [ACC_WIDTH-1:0] SUM_MAX = ACC_WIDTH'((64'd1 << SUM_WIDTH) - 64'd1);

    typedef enum logic [CLASS_WIDTH-1:0] {
        CLASS_DEFICIENT = 2'd0,
        CLASS_PERFECT   = 2'd1,
        CLASS_ABUNDANT  = 2'd2
    } class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_ACC,
        ST_FINISH
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic start_div;
        logic div_step;
        logic accum;
        logic emit;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic cand_done;
        logic last_step;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/asc_ctrl.sv
// sequencing state machine and result valid flag for the aliquot sum classifier
// depends on asc_pkg and aliquot_sum_classifier_defines.svh
`default_nettype none
`include "aliquot_sum_classifier_defines.svh"

module asc_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  asc_pkg::stat_t     stat_i,
    output asc_pkg::cmd_t      cmd_o
);
    import asc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = stat_i.cand_done ? ST_FINISH : ST_DIV;
            end
            ST_DIV: begin
                if (stat_i.last_step) state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = ST_CHECK;
            end
            ST_FINISH: begin
                if (slot_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd_o    = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd_o.load = s_tvalid;
            end
            ST_CHECK: begin
                cmd_o.start_div = !stat_i.cand_done;
            end
            ST_DIV: begin
                cmd_o.div_step = 1'b1;
            end
            ST_ACC: begin
                cmd_o.accum = 1'b1;
            end
            ST_FINISH: begin
                cmd_o.emit = slot_free;
            end
            default: begin
                cmd_o = '0;
            end
        endcase
    end

    always_comb begin
        if (cmd_o.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    `ASC_ASSERT(a_emit_slot_free, aclk, aresetn, cmd_o.emit |-> (!out_valid_reg || m_tready), "result overwritten before transaction")
    `ASC_ASSERT(a_valid_from_finish, aclk, aresetn, $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH), "result raised outside finish")
    `ASC_ASSERT(a_acc_after_div, aclk, aresetn, (state_reg == ST_ACC) |-> $past(state_reg == ST_DIV), "accumulate without division")

endmodule

`default_nettype wire

>>> rtl/asc_datapath.sv
// trial divisor, bit-serial remainder unit, divisor sum and result register
// depends on asc_pkg and aliquot_sum_classifier_defines.svh
`default_nettype none
`include "aliquot_sum_classifier_defines.svh"

module asc_datapath (
    input  wire logic                             aclk,
    input  asc_pkg::cmd_t                         cmd_i,
    output asc_pkg::stat_t                        stat_o,
    input  wire logic [asc_pkg::VALUE_WIDTH-1:0]  number_i,
    input  wire logic                             final_i,
    output logic [asc_pkg::SUM_WIDTH-1:0]         divisor_sum_o,
    output asc_pkg::class_t                       number_class_o,
    output logic                                  final_result_o
);
    import asc_pkg::*;

    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic                   last_reg, last_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [VALUE_WIDTH:0]   rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dvd_reg, dvd_next;
    logic [STEP_WIDTH-1:0]  step_reg, step_next;
    logic [ACC_WIDTH-1:0]   acc_reg, acc_next;
    logic [SUM_WIDTH-1:0]   out_sum_reg, out_sum_next;
    class_t                 out_class_reg, out_class_next;
    logic                   out_last_reg, out_last_next;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   d_ext;
    logic [ACC_WIDTH-1:0]   n_ext;

    assign d_ext = {1'b0, d_reg};
    assign n_ext = ACC_WIDTH'(n_reg);
    assign trial = {rem_reg[VALUE_WIDTH-1:0], dvd_reg[VALUE_WIDTH-1]};

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        last_reg      <= last_next;
        d_reg         <= d_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        step_reg      <= step_next;
        acc_reg       <= acc_next;
        out_sum_reg   <= out_sum_next;
        out_class_reg <= out_class_next;
        out_last_reg  <= out_last_next;
    end

    always_comb begin
        n_next         = n_reg;
        last_next      = last_reg;
        d_next         = d_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        out_sum_next   = out_sum_reg;
        out_class_next = out_class_reg;
        out_last_next  = out_last_reg;

        if (cmd_i.load) begin
            n_next    = number_i;
            last_next = final_i;
            d_next    = VALUE_WIDTH'(1);
            acc_next  = '0;
        end

        if (cmd_i.start_div) begin
            rem_next  = '0;
            dvd_next  = n_reg;
            step_next = '0;
        end

        // one restoring step per cycle, msb first
        if (cmd_i.div_step) begin
            rem_next  = (trial >= d_ext) ? trial - d_ext : trial;
            dvd_next  = {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
            step_next = step_reg + STEP_WIDTH'(1);
        end

        if (cmd_i.accum) begin
            if (rem_reg == '0) acc_next = acc_reg + ACC_WIDTH'(d_reg);
            d_next = d_reg + VALUE_WIDTH'(1);
        end

        if (cmd_i.emit) begin
            out_sum_next  = (acc_reg > SUM_MAX) ? SUM_MAX[SUM_WIDTH-1:0] : acc_reg[SUM_WIDTH-1:0];
            out_last_next = last_reg;
            if (acc_reg < n_ext) begin
                out_class_next = CLASS_DEFICIENT;
            end else if (acc_reg == n_ext) begin
                out_class_next = CLASS_PERFECT;
            end else begin
                out_class_next = CLASS_ABUNDANT;
            end
        end
    end

    assign stat_o.cand_done = (d_reg >= n_reg);
    assign stat_o.last_step = (step_reg == STEP_WIDTH'(VALUE_WIDTH - 1));

    assign divisor_sum_o  = out_sum_reg;
    assign number_class_o = out_class_reg;
    assign final_result_o = out_last_reg;

    `ASC_ASSERT_NR(a_rem_below_divisor, aclk, cmd_i.accum |-> (rem_reg < d_ext), "remainder not reduced")
    `ASC_ASSERT_NR(a_sum_grows, aclk, cmd_i.accum |=> (acc_reg >= $past(acc_reg)), "divisor sum wrapped")
    `ASC_ASSERT_NR(a_divisor_nonzero, aclk, (cmd_i.start_div || cmd_i.div_step) |-> (d_reg != '0), "zero trial divisor")

endmodule

`default_nettype wire

>>> rtl/aliquot_sum_classifier.sv
// top level of the aliquot sum classifier: controller plus datapath
// depends on asc_pkg, asc_ctrl and asc_datapath
//
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   s_tdata: number; s_tlast: final_number
// m_       out  m_tvalid/m_tready   m_tdata: divisor_sum, number_class; m_tlast: final_result
//
// one item at a time; every candidate divisor from 1 to n-1 runs through a
// one-bit-per-cycle remainder unit, one candidate at a time: check, 16 steps, add
// the next item is taken while a finished result waits in the output register
// aresetn is synchronous; it clears the state machine and the output valid flag
`default_nettype none

module aliquot_sum_classifier (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [asc_pkg::S_TDATA_WIDTH-1:0]  s_tdata,  // number, then zero fill
    input  wire logic                               s_tlast,  // final_number
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [asc_pkg::M_TDATA_WIDTH-1:0]       m_tdata,  // divisor_sum, number_class, zero fill
    output logic                                    m_tlast   // final_result
);
    import asc_pkg::*;

    cmd_t                 cmd;
    stat_t                stat;
    logic [SUM_WIDTH-1:0] divisor_sum;
    class_t               number_class;

    asc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat_i   (stat),
        .cmd_o    (cmd)
    );

    asc_datapath u_datapath (
        .aclk           (aclk),
        .cmd_i          (cmd),
        .stat_o         (stat),
        .number_i       (s_tdata[VALUE_WIDTH-1:0]),
        .final_i        (s_tlast),
        .divisor_sum_o  (divisor_sum),
        .number_class_o (number_class),
        .final_result_o (m_tlast)
    );

    assign m_tdata = M_TDATA_WIDTH'({number_class, divisor_sum});

endmodule

`default_nettype wire

>>> dv/aliquot_sum_classifier_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for aliquot_sum_classifier: directed table, then random numbers
// predicts sum and class if no table row gives them; depends on asc_pkg and rtl top level

module aliquot_sum_classifier_tb;

    localparam int NUM_W        = asc_pkg::VALUE_WIDTH;
    localparam int SUM_W        = asc_pkg::SUM_WIDTH;
    localparam int RANDOM_ITEMS = 100;
    localparam int QUIET_LIMIT  = 4_000_000;
    localparam int DIRECTED_N   = 14;
    localparam longint unsigned SUM_CEILING = (64'd1 << SUM_W) - 64'd1;

    typedef struct {
        logic [SUM_W-1:0] sum;
        asc_pkg::class_t  cls;
        logic             last;
    } verdict_t;

    typedef struct {
        logic [NUM_W-1:0] number;
        logic             last;
        bit               typed;
        logic [SUM_W-1:0] sum;
        asc_pkg::class_t  cls;
    } vector_t;

    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [asc_pkg::S_TDATA_WIDTH-1:0] s_tdata  = '0;  // number, then zero fill
    logic                              s_tlast  = 1'b0; // final_number
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [asc_pkg::M_TDATA_WIDTH-1:0] m_tdata;  // divisor_sum, number_class, zero fill
    logic                              m_tlast;  // final_result

    verdict_t pending_verdicts[$];
    vector_t  directed_plan [DIRECTED_N];
    int       mismatch_count = 0;
    int       quiet_cycles   = 0;

    aliquot_sum_classifier dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned proper_divisor_total(longint unsigned n);
        longint unsigned acc;
        longint unsigned d;
        acc = 0;
        if (n == 0) return 0;
        for (d = 1; d * d <= n; d++) begin
            if (n % d == 0) begin
                acc += d;
                if (n / d != d) acc += n / d;
            end
        end
        return acc - n;
    endfunction

    function automatic verdict_t classify_number(logic [NUM_W-1:0] number, logic last);
        verdict_t        v;
        longint unsigned total;
        total = proper_divisor_total(longint'(number));
        v.sum  = (total > SUM_CEILING) ? SUM_CEILING[SUM_W-1:0] : total[SUM_W-1:0];
        if (total < number)       v.cls = asc_pkg::CLASS_DEFICIENT;
        else if (total == number) v.cls = asc_pkg::CLASS_PERFECT;
        else                      v.cls = asc_pkg::CLASS_ABUNDANT;
        v.last = last;
        return v;
    endfunction

    function automatic int draw_pause(bit calm);
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    // one input transaction; returns at the edge where it is accepted
    task automatic send_number(logic [NUM_W-1:0] number, logic last, bit calm);
        int gap;
        gap = draw_pause(calm);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= asc_pkg::S_TDATA_WIDTH'(number);
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // result side: random stall before each transaction, calm stretches now and then
    initial begin
        int stall;
        int count;
        bit calm;
        count = 0;
        calm  = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (count % 10 == 0) calm = ($urandom_range(0, 3) == 0);
            count++;
            stall = draw_pause(calm);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result sum=%0d class=%0d last=%0b", $time,
                         m_tdata[SUM_W-1:0], m_tdata[SUM_W+1:SUM_W], m_tlast);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[SUM_W-1:0] !== want.sum) begin
                    mismatch_count++;
                    $display("%0t: divisor_sum expected %0d actual %0d", $time,
                             want.sum, m_tdata[SUM_W-1:0]);
                end
                if (m_tdata[SUM_W+1:SUM_W] !== want.cls) begin
                    mismatch_count++;
                    $display("%0t: number_class expected %0d actual %0d", $time,
                             want.cls, m_tdata[SUM_W+1:SUM_W]);
                end
                if (m_tlast !== want.last) begin
                    mismatch_count++;
                    $display("%0t: final_result expected %0b actual %0b", $time,
                             want.last, m_tlast);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("aliquot_sum_classifier regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        verdict_t         want;
        logic [NUM_W-1:0] number;
        int               pick;
        bit               calm;

        directed_plan = '{
            '{16'd0,     1'b0, 1'b1, 18'd0,    asc_pkg::CLASS_PERFECT},
            '{16'd1,     1'b1, 1'b1, 18'd0,    asc_pkg::CLASS_DEFICIENT},
            '{16'd2,     1'b0, 1'b0, 18'd0,    asc_pkg::CLASS_DEFICIENT},
            '{16'd7,     1'b0, 1'b0, 18'd0,    asc_pkg::CLASS_DEFICIENT},
            '{16'd6,     1'b1, 1'b1, 18'd6,    asc_pkg::CLASS_PERFECT},
            '{16'd12,    1'b0, 1'b0, 18'd0,    asc_pkg::CLASS_DEFICIENT},
            '{16'd16,    1'b0, 1'b0, 18'd0,    asc_pkg::CLASS_DEFICIENT},
            '{16'd28,    1'b1, 1'b1, 18'd28,   asc_pkg::CLASS_PERFECT},
            '{16'd945,   1'b0, 1'b0, 18'd0,    asc_pkg::CLASS_DEFICIENT},
            '{16'd496,   1'b0, 1'b1, 18'd496,  asc_pkg::CLASS_PERFECT},
            '{16'd720,   1'b1, 1'b0, 18'd0,    asc_pkg::CLASS_DEFICIENT},
            '{16'd8128,  1'b0, 1'b1, 18'd8128, asc_pkg::CLASS_PERFECT},
            '{16'd65535, 1'b1, 1'b0, 18'd0,    asc_pkg::CLASS_DEFICIENT},
            '{16'd3,     1'b0, 1'b0, 18'd0,    asc_pkg::CLASS_DEFICIENT}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        calm = 1'b0;
        for (int i = 0; i < DIRECTED_N; i++) begin
            if (directed_plan[i].typed) begin
                want.sum  = directed_plan[i].sum;
                want.cls  = directed_plan[i].cls;
                want.last = directed_plan[i].last;
            end else begin
                want = classify_number(directed_plan[i].number, directed_plan[i].last);
            end
            pending_verdicts.push_back(want);
            send_number(directed_plan[i].number, directed_plan[i].last, calm);
        end

        // mostly small numbers, since an item's run time grows with its value
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 12 == 0) calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 19);
            if (pick == 0)     number = NUM_W'($urandom_range(1024, 2047));
            else if (pick < 4) number = NUM_W'($urandom_range(256, 1023));
            else               number = NUM_W'($urandom_range(0, 255));
            want = classify_number(number, 1'($urandom_range(0, 1)));
            pending_verdicts.push_back(want);
            send_number(number, want.last, calm);
        end
        s_tvalid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("aliquot_sum_classifier regression: pass");
        end else begin
            $display("aliquot_sum_classifier regression: fail");
        end
        $finish;
    end

endmodule
